[rtl/core/cartridge_io_mapper_defines.svh]
// ---------------------------------------------------------------------------
// cartridge io mapper assertion macros
// shared property wrappers, compiled out when NO_ASSERTIONS is defined
// ---------------------------------------------------------------------------
`ifndef CARTRIDGE_IO_MAPPER_DEFINES_SVH
`define CARTRIDGE_IO_MAPPER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CIM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cartridge io mapper assertion failed");
`define CIM_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("cartridge io mapper forbidden condition seen");
`else
`define CIM_ASSERT(label, clk, rst_n, prop)
`define CIM_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

[rtl/core/cim_pkg.sv]
// ---------------------------------------------------------------------------
// cim_pkg
// shared types and constants of the cartridge io mapper
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cim_pkg;

  localparam int unsigned RamDepthDefault = 128;

  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_FREEZE = 2'd2;
  localparam logic [1:0] REQ_RESET  = 2'd3;

  localparam logic [15:0] IO1_LO = 16'hDE00;
  localparam logic [15:0] IO1_HI = 16'hDEFF;
  localparam logic [15:0] IO2_LO = 16'hDF00;
  localparam logic [15:0] IO2_HI = 16'hDFFF;
  localparam logic [12:0] ROM_BASE = 13'h1E00;
  localparam logic [7:0]  BYTE_IDLE = 8'hFF;

  localparam logic REG_RAM_PRESENT = 1'b0;
  localparam logic REG_ROM_MAPPED  = 1'b1;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ram_ctrl_t;

endpackage

[rtl/core/cim_ram.sv]
// ---------------------------------------------------------------------------
// cim_ram
// cartridge ram, one write and one registered read port, per-entry valid
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cim_ram #(
  parameter int unsigned RAM_DEPTH = cim_pkg::RamDepthDefault,
  localparam int unsigned AW = $clog2(RAM_DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cim_pkg::ram_ctrl_t ctrl_i,
  input  logic [AW-1:0]      addr_i,
  input  logic [7:0]         wdata_i,
  output logic [7:0]         rdata_o
);

  logic [7:0]           mem [RAM_DEPTH];
  logic [RAM_DEPTH-1:0] valid_q;
  logic [7:0]           rdata_q;
  logic                 rvalid_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        valid_q[addr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rvalid_q <= valid_q[addr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : 8'h00;

endmodule

[rtl/core/cim_ctrl.sv]
// ---------------------------------------------------------------------------
// cim_ctrl
// request decode, line levels and the result stage register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cartridge_io_mapper_defines.svh"

module cim_ctrl #(
  parameter int unsigned RAM_DEPTH = cim_pkg::RamDepthDefault,
  localparam int unsigned AW = $clog2(RAM_DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ram_present_i,
  input  logic               rom_mapped_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        address_i,
  input  logic [7:0]         wdata_i,
  input  logic [7:0]         rom_byte_i,
  input  logic [5:0]         open_bus_i,
  output cim_pkg::ram_ctrl_t ram_ctrl_o,
  output logic [AW-1:0]      ram_addr_o,
  output logic [7:0]         ram_wdata_o,
  input  logic [7:0]         ram_rdata_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         read_data_o,
  output logic [12:0]        rom_offset_o,
  output logic               game_line_o,
  output logic               exrom_line_o,
  output logic               nmi_request_o,
  output logic               warm_reset_request_o
);

  logic        accept;
  logic        io1, io2, low_half;
  logic        game_q, game_d, exrom_q, exrom_d;
  logic        out_valid_q;
  logic        use_ram_q, use_ram_d;
  logic [7:0]  rdata_q, rdata_d;
  logic [12:0] offset_q, offset_d;
  logic        nmi_q, nmi_d, warm_q, warm_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign io1      = (address_i >= cim_pkg::IO1_LO) && (address_i <= cim_pkg::IO1_HI);
  assign io2      = (address_i >= cim_pkg::IO2_LO) && (address_i <= cim_pkg::IO2_HI);
  assign low_half = !address_i[7];

  always_comb begin
    game_d    = game_q;
    exrom_d   = exrom_q;
    rdata_d   = cim_pkg::BYTE_IDLE;
    offset_d  = '0;
    use_ram_d = 1'b0;
    nmi_d     = 1'b0;
    warm_d    = 1'b0;
    unique case (req_type_i)
      cim_pkg::REQ_READ: begin
        if (io1) begin
          game_d   = 1'b1;
          exrom_d  = address_i[1];
          offset_d = cim_pkg::ROM_BASE + {5'd0, address_i[7:0]};
          rdata_d  = rom_byte_i;
        end else if (io2) begin
          if (low_half) begin
            use_ram_d = ram_present_i;
          end else begin
            // status byte sees the levels from before this request
            rdata_d = {exrom_q, game_q, open_bus_i};
          end
        end
      end
      cim_pkg::REQ_WRITE: begin
        if (io1) begin
          game_d  = 1'b0;
          exrom_d = address_i[1];
        end
      end
      cim_pkg::REQ_FREEZE: begin
        game_d  = 1'b0;
        exrom_d = 1'b1;
        nmi_d   = 1'b1;
      end
      cim_pkg::REQ_RESET: begin
        if (rom_mapped_i) begin
          game_d  = 1'b0;
          exrom_d = 1'b0;
        end
        warm_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign ram_ctrl_o.rd_en = accept && (req_type_i == cim_pkg::REQ_READ) && io2 && low_half
                            && ram_present_i;
  assign ram_ctrl_o.wr_en = accept && (req_type_i == cim_pkg::REQ_WRITE) && io2 && low_half
                            && ram_present_i;
  assign ram_addr_o  = address_i[AW-1:0];
  assign ram_wdata_o = wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      game_q      <= 1'b0;
      exrom_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        game_q  <= game_d;
        exrom_q <= exrom_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      use_ram_q <= use_ram_d;
      rdata_q   <= rdata_d;
      offset_q  <= offset_d;
      nmi_q     <= nmi_d;
      warm_q    <= warm_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign read_data_o          = use_ram_q ? ram_rdata_i : rdata_q;
  assign rom_offset_o         = offset_q;
  assign game_line_o          = game_q;
  assign exrom_line_o         = exrom_q;
  assign nmi_request_o        = nmi_q;
  assign warm_reset_request_o = warm_q;

  `CIM_ASSERT_NEVER(a_stall_without_result, clk_i, rst_ni, in_stall_o && !out_valid_q)
  `CIM_ASSERT(a_freeze_ultimax, clk_i, rst_ni,
              (out_valid_q && nmi_q) |-> (!game_q && exrom_q))
  `CIM_ASSERT(a_io1_write_lines, clk_i, rst_ni,
              (accept && req_type_i == cim_pkg::REQ_WRITE && io1)
              |=> (!game_q && exrom_q == $past(address_i[1])))
  `CIM_ASSERT_NEVER(a_ram_access_clash, clk_i, rst_ni, ram_ctrl_o.rd_en && ram_ctrl_o.wr_en)

endmodule

[rtl/core/cartridge_io_mapper.sv]
// ---------------------------------------------------------------------------
// cartridge_io_mapper
// expansion-port cartridge logic: io1/io2 decode, game/exrom lines, 128-byte ram
// ---------------------------------------------------------------------------
// result: the result register is loaded at the accepting edge
// throughput: one request per cycle, the result register refills at the edge that drains it
// a result waiting under out_stall_i holds off the next request until it is taken
// reset: both lines low, ram reads as zero via per-entry valid bits,
// ram_present and rom_mapped set
`timescale 1ns / 1ps

module cartridge_io_mapper #(
  parameter int unsigned RAM_DEPTH = cim_pkg::RamDepthDefault,
  localparam int unsigned AW = $clog2(RAM_DEPTH)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  wdata_i,
  input  logic [7:0]  rom_byte_i,
  input  logic [5:0]  open_bus_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic [12:0] rom_offset_o,
  output logic        game_line_o,
  output logic        exrom_line_o,
  output logic        nmi_request_o,
  output logic        warm_reset_request_o
);

  logic               ram_present_q, rom_mapped_q;
  logic               cfg_wr;
  cim_pkg::ram_ctrl_t ram_ctrl;
  logic [AW-1:0]      ram_addr;
  logic [7:0]         ram_wdata, ram_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_present_q <= 1'b1;
      rom_mapped_q  <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        cim_pkg::REG_RAM_PRESENT: ram_present_q <= pwdata[0];
        cim_pkg::REG_ROM_MAPPED:  rom_mapped_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      cim_pkg::REG_RAM_PRESENT: prdata = {31'd0, ram_present_q};
      cim_pkg::REG_ROM_MAPPED:  prdata = {31'd0, rom_mapped_q};
      default:                  prdata = '0;
    endcase
  end

  cim_ctrl #(
    .RAM_DEPTH(RAM_DEPTH)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .ram_present_i       (ram_present_q),
    .rom_mapped_i        (rom_mapped_q),
    .in_valid_i,
    .in_stall_o,
    .req_type_i,
    .address_i,
    .wdata_i,
    .rom_byte_i,
    .open_bus_i,
    .ram_ctrl_o          (ram_ctrl),
    .ram_addr_o          (ram_addr),
    .ram_wdata_o         (ram_wdata),
    .ram_rdata_i         (ram_rdata),
    .out_valid_o,
    .out_stall_i,
    .read_data_o,
    .rom_offset_o,
    .game_line_o,
    .exrom_line_o,
    .nmi_request_o,
    .warm_reset_request_o
  );

  cim_ram #(
    .RAM_DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk_i,
    .rst_ni,
    .ctrl_i  (ram_ctrl),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule
